// File: hw/rtl/stc_pkg.sv
// Shared types, character constants and decode functions for the script token scanner.
// No dependencies; every file of the block but stc_stream_if imports this package.
package stc_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int START_BITS            = 16;
    localparam int LEN_BITS              = 16;
    localparam int FIFO_DEPTH            = 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_STRING
    } scan_mode_t;

    // token kinds
    localparam logic [2:0] KIND_OP     = 3'd0;
    localparam logic [2:0] KIND_KW     = 3'd1;
    localparam logic [2:0] KIND_IDENT  = 3'd2;
    localparam logic [2:0] KIND_INT    = 3'd3;
    localparam logic [2:0] KIND_REAL   = 3'd4;
    localparam logic [2:0] KIND_STRING = 3'd5;
    localparam logic [2:0] KIND_SYMBOL = 3'd6;

    // operator codes
    localparam logic [7:0] OP_ASSIGN = 8'd0;
    localparam logic [7:0] OP_EQ     = 8'd1;
    localparam logic [7:0] OP_DEFINE = 8'd2;
    localparam logic [7:0] OP_PLUS   = 8'd3;
    localparam logic [7:0] OP_MINUS  = 8'd4;
    localparam logic [7:0] OP_MUL    = 8'd5;
    localparam logic [7:0] OP_DIV    = 8'd6;
    localparam logic [7:0] OP_NOT    = 8'd7;
    localparam logic [7:0] OP_NE     = 8'd8;
    localparam logic [7:0] OP_GT     = 8'd9;
    localparam logic [7:0] OP_GE     = 8'd10;
    localparam logic [7:0] OP_LT     = 8'd11;
    localparam logic [7:0] OP_LE     = 8'd12;
    localparam logic [7:0] OP_ARROW  = 8'd13;
    localparam logic [7:0] OP_LARROW = 8'd14;
    localparam logic [7:0] OP_OR     = 8'd15;
    localparam logic [7:0] OP_AND    = 8'd16;

    // keyword codes
    localparam logic [1:0] KW_TRUE   = 2'd0;
    localparam logic [1:0] KEY_FALSE = 2'd1;
    localparam logic [1:0] KW_NIL    = 2'd2;

    // ASCII
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_N = 8'h6E;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]            token_kind;
        logic [7:0]            token_code;
        logic [START_BITS-1:0] start_position;
        logic [LEN_BITS-1:0]   token_length;
        logic                  space_before;
        logic                  last_of_run;
    } token_t;

    // results of one scanned byte, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } stc_push_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } op_match_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // bytes that may start a two-character operator
    function automatic logic is_op_lead(logic [7:0] c);
        return c == CH_EQ || c == CH_MINUS || c == CH_BANG || c == CH_GT ||
               c == CH_LT || c == CH_COLON || c == CH_BAR || c == CH_AMP;
    endfunction

    function automatic op_match_t pair_code(logic [7:0] a, logic [7:0] b);
        op_match_t m;
        m.hit  = 1'b1;
        m.code = OP_ASSIGN;
        if (a == CH_COLON && b == CH_EQ)       m.code = OP_DEFINE;
        else if (a == CH_EQ && b == CH_EQ)     m.code = OP_EQ;
        else if (a == CH_MINUS && b == CH_GT)  m.code = OP_ARROW;
        else if (a == CH_BANG && b == CH_EQ)   m.code = OP_NE;
        else if (a == CH_GT && b == CH_EQ)     m.code = OP_GE;
        else if (a == CH_LT && b == CH_EQ)     m.code = OP_LE;
        else if (a == CH_LT && b == CH_MINUS)  m.code = OP_LARROW;
        else if (a == CH_BAR && b == CH_BAR)   m.code = OP_OR;
        else if (a == CH_AMP && b == CH_AMP)   m.code = OP_AND;
        else                                   m.hit  = 1'b0;
        return m;
    endfunction

    // lone operator byte; a miss means the byte closes as a symbol
    function automatic op_match_t single_code(logic [7:0] c);
        op_match_t m;
        m.hit  = 1'b1;
        m.code = OP_ASSIGN;
        if (c == CH_EQ)         m.code = OP_ASSIGN;
        else if (c == CH_MINUS) m.code = OP_MINUS;
        else if (c == CH_BANG)  m.code = OP_NOT;
        else if (c == CH_GT)    m.code = OP_GT;
        else if (c == CH_LT)    m.code = OP_LT;
        else                    m.hit  = 1'b0;
        return m;
    endfunction

    function automatic logic [LEN_BITS-1:0] kw_len(logic [1:0] k);
        logic [LEN_BITS-1:0] n;
        unique case (k)
            KW_TRUE:   n = LEN_BITS'(4);
            KEY_FALSE: n = LEN_BITS'(5);
            KW_NIL:    n = LEN_BITS'(3);
            default:   n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (k)
            KW_TRUE:
                unique case (i)
                    3'd0:    ch = 8'h74;
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            KEY_FALSE:
                unique case (i)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            KW_NIL:
                unique case (i)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h69;
                    3'd2:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/stc_stream_if.sv
// Valid/ready stream channel used by both sides of the token scanner.
// Payload type is set per instance; no package dependency.
interface stc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/script_token_scanner.sv
// Top level of the script token scanner: byte channel in, token channel out.
// Depends on stc_pkg, stc_stream_if, stc_scan and stc_result_fifo.
//
// Usage
//   byte_stream (sink): one source byte per transfer, payload byte_item_t
//   {char_in, end_of_input}. A transfer with end_of_input set closes any open
//   token and rewinds the byte offset to zero for the next source.
//   token_stream (source): one token per transfer, payload token_t.
//   last_of_run marks the final token caused by one input byte.
// Ordering: the tokens caused by a byte are written to the result queue at
//   that byte's transfer; the second token of a byte follows the first.
// Throughput: one byte per cycle while the result queue has room. The rate
//   is set by the output side, which takes one transfer per token, so a byte
//   that yields two tokens holds it longer. The scanner state updates once per byte.
// Stall: tokens collect in a 4-entry result queue. byte_stream.ready is high
//   while at least two entries are free, so input keeps flowing while a
//   finished token waits on a stalled receiver, and drops only once the queue
//   backs up.
// Reset: rst_n (async, active low) empties the queue and returns the scanner
//   to idle at byte offset zero with no whitespace seen.
module script_token_scanner #(
    parameter int POSITION_BITS = stc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    stc_stream_if.sink   byte_stream,
    stc_stream_if.source token_stream
);
    import stc_pkg::*;

    stc_push_t push;
    logic      step;
    logic      room;

    // a byte transfer completes here; the scanner advances on it
    assign step              = byte_stream.valid && byte_stream.ready;
    assign byte_stream.ready = room;

    stc_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (byte_stream.payload),
        .push  (push)
    );

    stc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (token_stream.valid),
        .out_ready (token_stream.ready),
        .out_token (token_stream.payload)
    );

    // an empty output side must never hold off input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !token_stream.valid |-> byte_stream.ready)
        else $error("input stalled with no tokens queued");

    // tokens are only produced by an accepted byte
    a_push_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> step)
        else $error("tokens pushed without a byte transfer");

    // a two-token byte marks only its second token as last of run
    a_pair_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run))
        else $error("last_of_run misplaced on a two-token byte");

    // no unknown kind ever reaches the receiver
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        token_stream.valid |-> (token_stream.payload.token_kind <= KIND_SYMBOL))
        else $error("token kind out of range");

endmodule

// File: hw/rtl/stc_scan.sv
// Scanner state and per-byte decode: turns one accepted byte into zero, one or two tokens.
// Depends on stc_pkg.
module stc_scan #(
    parameter int POSITION_BITS = stc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  stc_pkg::byte_item_t item,
    output stc_pkg::stc_push_t  push
);
    import stc_pkg::*;

    scan_mode_t                mode_reg, mode_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [POSITION_BITS-1:0]  tstart_reg, tstart_next;
    logic [LEN_BITS-1:0]       count_reg, count_next;
    logic [7:0]                pend_reg, pend_next;
    logic [2:0]                kwf_reg, kwf_next;
    logic                      space_reg, space_next;

    logic [7:0]  c;
    logic        eoi;
    logic        c_space, c_digit, c_alpha, c_alnum, c_lead, c_quote, c_dot;
    op_match_t   pair, lone;
    logic        pair_hit, cont, close_now, fresh, emit_a, emit_b;
    logic [2:0]  kw_mask;
    logic [2:0]  kw_init;
    logic [LEN_BITS-1:0]      count_inc;
    logic [POSITION_BITS-1:0] pos_inc, tstart_inc, a_pos;
    logic [POSITION_BITS+START_BITS-1:0] a_ext, b_ext;
    logic [START_BITS-1:0]    a_start, b_start;
    token_t tok_a, tok_b;

    assign c       = item.char_in;
    assign eoi     = item.end_of_input;
    assign c_space = is_space(c);
    assign c_digit = is_digit(c);
    assign c_alpha = is_alpha(c);
    assign c_alnum = c_alpha || c_digit;
    assign c_lead  = is_op_lead(c);
    assign c_quote = (c == CH_QUOTE);
    assign c_dot   = (c == CH_DOT);
    assign pair    = pair_code(pend_reg, c);
    assign lone    = single_code(pend_reg);

    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + LEN_BITS'(1);
    assign pos_inc    = (pos_reg == '1) ? pos_reg : pos_reg + POSITION_BITS'(1);
    assign tstart_inc = (tstart_reg == '1) ? tstart_reg : tstart_reg + POSITION_BITS'(1);

    // keyword letters still matching at the current offset
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            kw_mask[k] = (count_reg < kw_len(2'(k))) &&
                         (kw_char(2'(k), count_reg[2:0]) == c);
        end
        kw_init = {c == CH_LOW_N, c == CH_LOW_F, c == CH_LOW_T};
    end

    // shared decode
    always_comb
    begin
        unique case (mode_reg)
            MODE_IDENT:  cont = c_alnum;
            MODE_INT:    cont = c_digit || c_dot;
            MODE_FRAC:   cont = c_digit;
            MODE_STRING: cont = !c_quote;
            default:     cont = 1'b0;
        endcase
    end

    assign pair_hit  = !eoi && (mode_reg == MODE_OP) && pair.hit;
    assign close_now = eoi ? (mode_reg != MODE_IDLE)
                           : ((mode_reg == MODE_OP) && !pair.hit) ||
                             ((mode_reg != MODE_IDLE) && (mode_reg != MODE_OP) && !cont);
    assign fresh     = !eoi && ((mode_reg == MODE_IDLE) ||
                                (close_now && (mode_reg != MODE_STRING)));
    assign emit_a    = pair_hit || close_now;
    assign emit_b    = fresh && !(c_space || c_lead || c_alpha || c_digit || c_quote);

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_inc;
        tstart_next = tstart_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        kwf_next    = kwf_reg;
        space_next  = space_reg;
        if (eoi)
        begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            space_next = 1'b0;
            pend_next  = 8'h00;
        end
        else
        begin
            if (pair_hit || close_now)
                mode_next = MODE_IDLE;
            if (cont)
            begin
                count_next = count_inc;
                if (mode_reg == MODE_INT && c_dot)
                    mode_next = MODE_FRAC;
                if (mode_reg == MODE_IDENT)
                    kwf_next = kwf_reg & kw_mask;
            end
            if (fresh)
            begin
                tstart_next = pos_reg;
                count_next  = c_quote ? '0 : LEN_BITS'(1);
                priority if (c_lead)
                begin
                    mode_next = MODE_OP;
                    pend_next = c;
                end
                else if (c_alpha)
                begin
                    mode_next = MODE_IDENT;
                    kwf_next  = kw_init;
                end
                else if (c_digit)
                    mode_next = MODE_INT;
                else if (c_quote)
                    mode_next = MODE_STRING;
                else
                    mode_next = MODE_IDLE;
            end
            if (fresh && c_space)
                space_next = 1'b1;
            else if (emit_a || emit_b)
                space_next = 1'b0;
        end
    end

    // start offsets, clipped to the output field
    assign a_pos   = (mode_reg == MODE_STRING) ? tstart_inc : tstart_reg;
    assign a_ext   = {START_BITS'(0), a_pos};
    assign b_ext   = {START_BITS'(0), pos_reg};
    assign a_start = (|a_ext[POSITION_BITS+START_BITS-1:START_BITS]) ? '1 : a_ext[START_BITS-1:0];
    assign b_start = (|b_ext[POSITION_BITS+START_BITS-1:START_BITS]) ? '1 : b_ext[START_BITS-1:0];

    // outputs
    always_comb
    begin
        tok_a.start_position = a_start;
        tok_a.token_length   = count_reg;
        tok_a.space_before   = space_reg;
        tok_a.last_of_run    = 1'b0;
        tok_a.token_code     = 8'h00;
        tok_a.token_kind     = KIND_IDENT;
        if (pair_hit)
        begin
            tok_a.token_kind   = KIND_OP;
            tok_a.token_code   = pair.code;
            tok_a.token_length = LEN_BITS'(2);
        end
        else
        begin
            unique case (mode_reg)
                MODE_OP:
                begin
                    tok_a.token_kind   = lone.hit ? KIND_OP : KIND_SYMBOL;
                    tok_a.token_code   = lone.hit ? lone.code : pend_reg;
                    tok_a.token_length = LEN_BITS'(1);
                end
                MODE_IDENT:
                begin
                    priority if (kwf_reg[KW_TRUE] && count_reg == kw_len(KW_TRUE))
                    begin
                        tok_a.token_kind = KIND_KW;
                        tok_a.token_code = 8'(KW_TRUE);
                    end
                    else if (kwf_reg[KEY_FALSE] && count_reg == kw_len(KEY_FALSE))
                    begin
                        tok_a.token_kind = KIND_KW;
                        tok_a.token_code = 8'(KEY_FALSE);
                    end
                    else if (kwf_reg[KW_NIL] && count_reg == kw_len(KW_NIL))
                    begin
                        tok_a.token_kind = KIND_KW;
                        tok_a.token_code = 8'(KW_NIL);
                    end
                    else
                        tok_a.token_kind = KIND_IDENT;
                end
                MODE_INT:    tok_a.token_kind = KIND_INT;
                MODE_FRAC:   tok_a.token_kind = KIND_REAL;
                MODE_STRING: tok_a.token_kind = KIND_STRING;
                default:     tok_a.token_kind = KIND_IDENT;
            endcase
        end

        tok_b.start_position = b_start;
        tok_b.token_length   = LEN_BITS'(1);
        tok_b.space_before   = emit_a ? 1'b0 : space_reg;
        tok_b.last_of_run    = 1'b1;
        tok_b.token_kind     = KIND_OP;
        priority if (c == CH_PLUS)
            tok_b.token_code = OP_PLUS;
        else if (c == CH_STAR)
            tok_b.token_code = OP_MUL;
        else if (c == CH_SLASH)
            tok_b.token_code = OP_DIV;
        else
        begin
            tok_b.token_kind = KIND_SYMBOL;
            tok_b.token_code = c;
        end

        push.count  = 2'd0;
        push.first  = tok_a;
        push.second = tok_b;
        if (step)
        begin
            push.count = {1'b0, emit_a} + {1'b0, emit_b};
            if (emit_a && !emit_b)
                push.first.last_of_run = 1'b1;
            else if (!emit_a)
                push.first = tok_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            count_reg  <= '0;
            pend_reg   <= 8'h00;
            kwf_reg    <= 3'b111;
            space_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            kwf_reg    <= kwf_next;
            space_reg  <= space_next;
        end
    end

endmodule

// File: hw/rtl/stc_result_fifo.sv
// Result queue: up to two tokens in a cycle, one out a cycle on out_ready.
// Depends on stc_pkg.
module stc_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  stc_pkg::stc_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output stc_pkg::token_t    out_token
);
    import stc_pkg::*;

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    token_t              mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                pop;

    assign out_valid = (cnt_reg != '0);
    assign out_token = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    // room for a two-token byte even when nothing drains this cycle
    assign room      = (cnt_reg <= CNT_BITS'(FIFO_DEPTH - 2));

    assign wr_next  = wr_reg + PTR_BITS'(push.count);
    assign rd_next  = rd_reg + PTR_BITS'(pop);
    assign cnt_next = cnt_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_reg + PTR_BITS'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: tb/sv/tb_script_token_scanner.sv
// Self-checking bench for script_token_scanner: random and directed byte streams in,
// every token checked field by field against an in-bench scanner model.
// Depends on stc_pkg, stc_stream_if and the scanner RTL.
module tb_script_token_scanner;
    import stc_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          RANDOM_BYTES  = 320;
    localparam int          CALM_BYTES    = 50;
    localparam int          HOLD_AFTER    = 150;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          LONG_BODY     = 16;
    localparam int          REPORT_CAP    = 40;
    localparam logic [15:0] COUNT_TOP     = 16'hFFFF;

    typedef struct packed {
        byte_item_t item;
        logic       drain_first;  // hold this byte back until every token is in
        logic       calm;         // end section: no idling on either side
    } queued_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    stc_stream_if #(.payload_t(byte_item_t)) byte_if ();
    stc_stream_if #(.payload_t(token_t))     token_if ();

    script_token_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_if),
        .token_stream (token_if)
    );

    logic       send_valid = 1'b0;
    byte_item_t send_item  = '0;
    logic       take_ready = 1'b0;
    logic       quiet_tail = 1'b0;
    logic       long_hold  = 1'b0;

    assign byte_if.valid    = send_valid;
    assign byte_if.payload  = send_item;
    assign token_if.ready   = take_ready;

    queued_byte_t byte_backlog[$];
    token_t       expected_tokens[$];
    token_t       step_toks[$];

    int mismatch_count = 0;
    int tokens_seen    = 0;
    int bytes_accepted = 0;
    int sources_done   = 0;
    int cycle_count    = 0;
    int send_gap       = 0;
    int send_steady    = 0;
    int take_stall     = 0;
    int take_steady    = 0;

    logic gen_calm  = 1'b0;
    logic gen_drain = 1'b0;

    string kw_words[3] = '{"true", "false", "nil"};
    string op_spellings[20] = '{"=", "==", ":=", "+", "-", "*", "/", "!", "!=", ">",
                                ">=", "<", "<=", "->", "<-", "||", "&&", ":", "|", "&"};
    string kw_lookalikes[16] = '{"true", "false", "nil", "tru", "fals", "ni", "truex",
                                 "nil0", "falses", "t", "f", "n", "trUe", "NIL", "nill",
                                 "ftrue"};
    string punct_bytes = "(){}[],;#$%^~@?'.\\";

    // ------------------------------------------------------------------
    // Scanner model state
    // ------------------------------------------------------------------
    scan_mode_t  sc_mode  = MODE_IDLE;
    logic [15:0] sc_pos   = '0;
    logic [15:0] sc_start = '0;
    logic [15:0] sc_chars = '0;
    logic [7:0]  sc_pend  = '0;
    logic [2:0]  sc_kw    = 3'b111;
    logic        sc_space = 1'b0;

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v == COUNT_TOP) ? v : v + 16'd1;
    endfunction

    function automatic logic ws_byte(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic digit_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter_byte(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic lead_byte(logic [7:0] c);
        return c == CH_EQ || c == CH_MINUS || c == CH_BANG || c == CH_GT ||
               c == CH_LT || c == CH_COLON || c == CH_BAR || c == CH_AMP;
    endfunction

    // {hit, code} for a two-byte operator
    function automatic logic [8:0] pair_op(logic [7:0] a, logic [7:0] b);
        if (a == CH_COLON && b == CH_EQ) return {1'b1, OP_DEFINE};
        if (a == CH_EQ && b == CH_EQ) return {1'b1, OP_EQ};
        if (a == CH_MINUS && b == CH_GT) return {1'b1, OP_ARROW};
        if (a == CH_BANG && b == CH_EQ) return {1'b1, OP_NE};
        if (a == CH_GT && b == CH_EQ) return {1'b1, OP_GE};
        if (a == CH_LT && b == CH_EQ) return {1'b1, OP_LE};
        if (a == CH_LT && b == CH_MINUS) return {1'b1, OP_LARROW};
        if (a == CH_BAR && b == CH_BAR) return {1'b1, OP_OR};
        if (a == CH_AMP && b == CH_AMP) return {1'b1, OP_AND};
        return '0;
    endfunction

    task automatic emit_token(input logic [2:0] kind, input logic [7:0] code,
                              input logic [15:0] start, input logic [15:0] len);
        token_t t;
        t.token_kind     = kind;
        t.token_code     = code;
        t.start_position = start;
        t.token_length   = len;
        t.space_before   = sc_space;
        t.last_of_run    = 1'b0;
        sc_space = 1'b0;
        step_toks.push_back(t);
    endtask

    task automatic close_token();
        logic found;
        found = 1'b0;
        case (sc_mode)
            MODE_OP:
            begin
                case (sc_pend)
                    CH_EQ:    emit_token(KIND_OP, OP_ASSIGN, sc_start, 16'd1);
                    CH_MINUS: emit_token(KIND_OP, OP_MINUS, sc_start, 16'd1);
                    CH_BANG:  emit_token(KIND_OP, OP_NOT, sc_start, 16'd1);
                    CH_GT:    emit_token(KIND_OP, OP_GT, sc_start, 16'd1);
                    CH_LT:    emit_token(KIND_OP, OP_LT, sc_start, 16'd1);
                    default:  emit_token(KIND_SYMBOL, sc_pend, sc_start, 16'd1);
                endcase
            end
            MODE_IDENT:
            begin
                // keywords need an exact length match, not just a prefix
                for (int k = KW_TRUE; k <= KW_NIL; k++)
                begin
                    if (!found && sc_kw[k] && sc_chars == 16'(kw_words[k].len()))
                    begin
                        emit_token(KIND_KW, 8'(k), sc_start, sc_chars);
                        found = 1'b1;
                    end
                end
                if (!found)
                    emit_token(KIND_IDENT, 8'd0, sc_start, sc_chars);
            end
            MODE_INT:    emit_token(KIND_INT, 8'd0, sc_start, sc_chars);
            MODE_FRAC:   emit_token(KIND_REAL, 8'd0, sc_start, sc_chars);
            MODE_STRING: emit_token(KIND_STRING, 8'd0, bump(sc_start), sc_chars);
            default:     ;
        endcase
        sc_mode = MODE_IDLE;
    endtask

    task automatic open_token(input logic [7:0] c, input logic [15:0] p);
        sc_start = p;
        sc_chars = 16'd1;
        if (ws_byte(c))
            sc_space = 1'b1;
        else if (lead_byte(c))
        begin
            sc_pend = c;
            sc_mode = MODE_OP;
        end
        else if (c == CH_PLUS)
            emit_token(KIND_OP, OP_PLUS, p, 16'd1);
        else if (c == CH_STAR)
            emit_token(KIND_OP, OP_MUL, p, 16'd1);
        else if (c == CH_SLASH)
            emit_token(KIND_OP, OP_DIV, p, 16'd1);
        else if (letter_byte(c))
        begin
            sc_kw = '0;
            for (int k = KW_TRUE; k <= KW_NIL; k++)
                if (kw_words[k][0] == c)
                    sc_kw[k] = 1'b1;
            sc_mode = MODE_IDENT;
        end
        else if (digit_byte(c))
            sc_mode = MODE_INT;
        else if (c == CH_QUOTE)
        begin
            sc_chars = '0;
            sc_mode  = MODE_STRING;
        end
        else
            emit_token(KIND_SYMBOL, c, p, 16'd1);
    endtask

    // Advance the model by one accepted byte and queue the tokens it yields.
    task automatic predict_tokens(input byte_item_t b);
        logic [7:0]  c;
        logic [15:0] p;
        logic [8:0]  pair;
        logic        fresh;
        token_t      t;
        c     = b.char_in;
        p     = sc_pos;
        fresh = 1'b0;
        step_toks.delete();
        if (b.end_of_input)
        begin
            close_token();
            sc_pos   = '0;
            sc_space = 1'b0;
            sc_pend  = '0;
        end
        else
        begin
            case (sc_mode)
                MODE_OP:
                begin
                    pair = pair_op(sc_pend, c);
                    if (pair[8])
                    begin
                        emit_token(KIND_OP, pair[7:0], sc_start, 16'd2);
                        sc_mode = MODE_IDLE;
                    end
                    else
                    begin
                        close_token();
                        fresh = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (letter_byte(c) || digit_byte(c))
                    begin
                        for (int k = KW_TRUE; k <= KW_NIL; k++)
                            if (!(sc_chars < kw_words[k].len() && kw_words[k][sc_chars] == c))
                                sc_kw[k] = 1'b0;
                        sc_chars = bump(sc_chars);
                    end
                    else
                    begin
                        close_token();
                        fresh = 1'b1;
                    end
                end
                MODE_INT:
                begin
                    // a dot always turns the number into a real
                    if (digit_byte(c) || c == CH_DOT)
                    begin
                        if (c == CH_DOT)
                            sc_mode = MODE_FRAC;
                        sc_chars = bump(sc_chars);
                    end
                    else
                    begin
                        close_token();
                        fresh = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    if (digit_byte(c))
                        sc_chars = bump(sc_chars);
                    else
                    begin
                        close_token();
                        fresh = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (c == CH_QUOTE)
                        close_token();
                    else
                        sc_chars = bump(sc_chars);
                end
                default: fresh = 1'b1;
            endcase
            if (fresh)
                open_token(c, p);
            sc_pos = bump(p);
        end
        if (step_toks.size() != 0)
        begin
            t = step_toks.pop_back();
            t.last_of_run = 1'b1;
            step_toks.push_back(t);
        end
        foreach (step_toks[i])
            expected_tokens.push_back(step_toks[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_item(input logic [7:0] c, input logic eoi);
        queued_byte_t q;
        q.item.char_in      = eoi ? 8'($urandom_range(0, 255)) : c;
        q.item.end_of_input = eoi;
        q.drain_first       = gen_drain;
        q.calm              = gen_calm;
        gen_drain = 1'b0;
        byte_backlog.push_back(q);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? "A" + 8'(r) : "a" + 8'(r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 4) == 0) ? "0" + 8'($urandom_range(0, 9)) : rand_letter();
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(9 + r);
    endfunction

    // One lexeme-sized chunk; mostly well-formed tokens, some noise.
    task automatic add_random_lexeme();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            push_item(8'($urandom_range(0, 255)), 1'b0);
        else if (pick < 24)
        begin
            if ($urandom_range(0, 1) == 1)
                push_text(kw_lookalikes[$urandom_range(0, 15)]);
            else
            begin
                push_item(rand_letter(), 1'b0);
                repeat ($urandom_range(0, 6)) push_item(rand_alnum(), 1'b0);
            end
        end
        else if (pick < 38)
        begin
            repeat ($urandom_range(1, 5)) push_item("0" + 8'($urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 2) == 0)
            begin
                push_item(CH_DOT, 1'b0);
                repeat ($urandom_range(0, 3)) push_item("0" + 8'($urandom_range(0, 9)), 1'b0);
            end
        end
        else if (pick < 56)
            push_text(op_spellings[$urandom_range(0, 19)]);
        else if (pick < 66)
        begin
            push_item(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 6))
            begin
                c = 8'($urandom_range(0, 255));
                push_item((c == CH_QUOTE) ? CH_SPACE : c, 1'b0);
            end
            // now and then leave it open so it runs into later bytes or the end
            if ($urandom_range(0, 7) != 0)
                push_item(CH_QUOTE, 1'b0);
        end
        else if (pick < 76)
        begin
            case ($urandom_range(0, 3))
                0:       push_item(8'h00, 1'b0);
                1:       push_item(8'($urandom_range(128, 255)), 1'b0);
                2:       push_item(punct_bytes[$urandom_range(0, punct_bytes.len() - 1)], 1'b0);
                default: push_item(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        else if (pick < 95)
            repeat ($urandom_range(1, 3)) push_item(rand_space(), 1'b0);
        else
            push_item(8'h00, 1'b1);
    endtask

    task automatic add_random_bytes(input int count);
        int target;
        target = byte_backlog.size() + count;
        while (byte_backlog.size() < target)
            add_random_lexeme();
        push_item(8'h00, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        // count everything, but keep the log readable on a badly broken build
        if (mismatch_count < REPORT_CAP)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("token %0d %s got %0d expected %0d",
                                      tokens_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the main sequence
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        // every operator, adjacent so each pair is split the right way
        push_text("==:=+-*/!=!>=><=<-->||&&=<");
        push_item(8'h00, 1'b1);
        // whitespace kinds, lone colon/bar/amp, "1." real, odd bytes,
        // keyword and a string left open at the end of the source
        push_item(8'd9, 1'b0);
        push_item(CH_COLON, 1'b0);
        push_item(8'd10, 1'b0);
        push_item(CH_BAR, 1'b0);
        push_item(8'd11, 1'b0);
        push_item(CH_AMP, 1'b0);
        push_item(8'd12, 1'b0);
        push_text("1.");
        push_item(8'd13, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'hFF, 1'b0);
        push_text(" true \"ab");
        push_item(8'h00, 1'b1);

        gen_drain = 1'b1;
        add_random_bytes(RANDOM_BYTES);

        // end section: drained start, no idling, then a longer string
        // and a one-letter source
        gen_drain = 1'b1;
        gen_calm  = 1'b1;
        add_random_bytes(CALM_BYTES);
        push_item(CH_QUOTE, 1'b0);
        repeat (LONG_BODY) push_item(8'($urandom_range(35, 126)), 1'b0);
        push_text("\"xy \"b\"7");
        push_item(8'h00, 1'b1);
        push_text("q");
        push_item(8'h00, 1'b1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_backlog.size() != 0 || send_valid)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d source bytes in %0d sources and checked %0d tokens,",
                 bytes_accepted, sources_done, tokens_seen);
        $display("including a long output hold, drained restarts and open strings at end.");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Long receiver hold, once, while the sender keeps offering bytes.
    initial
    begin
        while (bytes_accepted < HOLD_AFTER)
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_driver
        queued_byte_t nxt;
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_item  <= '0;
            quiet_tail <= 1'b0;
        end
        else if (send_valid && !byte_if.ready)
        begin
            // transfer still pending, keep the byte steady
        end
        else if (send_gap != 0)
        begin
            send_gap--;
            send_valid <= 1'b0;
        end
        else if (byte_backlog.size() != 0 &&
                 (!byte_backlog[0].drain_first ||
                  (!send_valid && expected_tokens.size() == 0)))
        begin
            nxt = byte_backlog.pop_front();
            send_valid <= 1'b1;
            send_item  <= nxt.item;
            quiet_tail <= nxt.calm;
            if (!nxt.calm && !long_hold)
            begin
                if (send_steady != 0)
                    send_steady--;
                else if ($urandom_range(0, 49) == 0)
                    send_steady = $urandom_range(20, 80);
                else if ($urandom_range(0, 6) == 0)
                    send_gap = $urandom_range(1, 13);
            end
        end
        else
            send_valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Token receiver: random stall bursts, steady stretches, long hold
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : token_receiver
        if (!rst_n)
            take_ready <= 1'b0;
        else if (long_hold)
            take_ready <= 1'b0;
        else if (quiet_tail)
            take_ready <= 1'b1;
        else if (take_stall != 0)
        begin
            take_stall--;
            take_ready <= 1'b0;
        end
        else
        begin
            take_ready <= 1'b1;
            if (take_steady != 0)
                take_steady--;
            else if ($urandom_range(0, 39) == 0)
                take_steady = $urandom_range(20, 80);
            else if ($urandom_range(0, 5) == 0)
                take_stall = $urandom_range(1, 13);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on byte transfers, check on token transfers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        token_t got;
        token_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (byte_if.valid && byte_if.ready)
            begin
                bytes_accepted++;
                if (byte_if.payload.end_of_input)
                    sources_done++;
                predict_tokens(byte_if.payload);
            end
            if (token_if.valid && token_if.ready)
            begin
                got = token_if.payload;
                tokens_seen++;
                if (expected_tokens.size() == 0)
                    report_mismatch($sformatf("token %0d arrived with none pending",
                                              tokens_seen));
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", 32'(got.token_kind), 32'(want.token_kind));
                    check_field("token_code", 32'(got.token_code), 32'(want.token_code));
                    check_field("start_position", 32'(got.start_position),
                                32'(want.start_position));
                    check_field("token_length", 32'(got.token_length),
                                32'(want.token_length));
                    check_field("space_before", 32'(got.space_before),
                                32'(want.space_before));
                    check_field("last_of_run", 32'(got.last_of_run),
                                32'(want.last_of_run));
                end
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d tokens still pending",
                         cycle_count, expected_tokens.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

// File: filelist.f
hw/rtl/stc_pkg.sv
hw/rtl/stc_stream_if.sv
hw/rtl/stc_scan.sv
hw/rtl/stc_result_fifo.sv
hw/rtl/script_token_scanner.sv
tb/sv/tb_script_token_scanner.sv
